@@ rtl/core/descriptor_chain_dma_engine_unit_defines.svh @@
// Assertion macros used by the checker file
`ifndef DESCRIPTOR_CHAIN_DMA_ENGINE_UNIT_DEFINES_SVH
`define DESCRIPTOR_CHAIN_DMA_ENGINE_UNIT_DEFINES_SVH
// a condition implies a consequence on the same edge
`define DCD_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);
// a condition implies a consequence with non-overlapping implication
`define DCD_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);
`endif

@@ rtl/core/dcd_pkg.sv @@
// Package: codes and constants of the descriptor chain DMA engine
package dcd_pkg;
    typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_FETCH = 2'd1, PH_TOSCR = 2'd2,
                              PH_FROMSCR = 2'd3} phase_t;
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_MEM_RET = 2'd2;
    localparam logic [1:0] ACT_SCR_RET = 2'd3;
    localparam logic [1:0] REG_CONFIG = 2'd0;
    localparam logic [1:0] REG_CONTROL = 2'd1;
    localparam logic [1:0] REG_START = 2'd2;
    localparam logic [1:0] REG_NEXT = 2'd3;
    localparam logic [2:0] CTL_START = 3'd1;
    localparam logic [2:0] CTL_STOP = 3'd2;
    localparam logic [2:0] CTL_FREEZE = 3'd3;
    localparam logic [2:0] CTL_UNFREEZE = 3'd4;
    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_MAP = 2'd1;
    localparam logic [1:0] ERR_FORMAT = 2'd2;
    localparam logic [1:0] SP_X = 2'd0;
    localparam logic [1:0] SP_Y = 2'd1;
    localparam logic [1:0] SP_P = 2'd2;
    localparam logic [2:0] WIDX_OWED = 3'd7;
    localparam logic [3:0] BUF_CIRCULAR = 4'hE;
endpackage

@@ rtl/core/descriptor_chain_dma_engine_unit.sv @@
// Top level: descriptor chain DMA engine with registered result stage
// Channel | Direction | Handshake           | Payload
// in      | into      | in_valid/in_stall   | action, reg_select, write_value, mem_rdata,
//         |           |                     | scratch_rdata
// out     | out of    | out_valid/out_stall | reg_rdata, mem_*, scratch_*, error
// Sequencer state and result register update at the same edge when a word is accepted.
// A new word is accepted every cycle while the result register is empty or drains.
// in_stall follows out_stall only while a result is held, so a full pipe holds.
// Reset clears the sequencer, flags and registers, but not the result or descriptor copy.
module descriptor_chain_dma_engine_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  action,
    input  logic [1:0]  reg_select,
    input  logic [31:0] write_value,
    input  logic [23:0] mem_rdata,
    input  logic [31:0] scratch_rdata,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] reg_rdata,
    output logic [1:0]  mem_op,
    output logic [1:0]  mem_region,
    output logic [12:0] mem_addr,
    output logic [23:0] mem_wdata,
    output logic [1:0]  scratch_op,
    output logic [31:0] scratch_loc,
    output logic [2:0]  scratch_bytes,
    output logic [31:0] scratch_wdata,
    output logic [1:0]  error
);
    import dcd_pkg::*;

    logic [31:0] config_reg, start_reg, next_ptr_reg, scr_ptr_reg;
    logic [31:0] config_next_c, start_next_c;
    logic [31:0] next_ptr_next, scr_ptr_next;
    logic [2:0]  flags_reg, flags_next;
    logic        eol_reg, eol_next;
    phase_t      phase_reg, phase_next;
    logic [2:0]  widx_reg, widx_next;
    logic [13:0] node_reg, node_next;
    logic [23:0] item_reg, item_next;
    logic [23:0] desc_reg [6];
    logic        desc_we;
    logic [2:0]  desc_wa;
    logic        out_valid_reg;
    logic        accept;

    logic [31:0] r_rdata;
    logic [1:0]  r_mop, r_msp, r_sop, r_err;
    logic [12:0] r_maddr;
    logic [23:0] r_mwd;
    logic [31:0] r_saddr, r_swd;
    logic [2:0]  r_sbytes;

    logic [31:0] rdata_reg, saddr_reg, swd_reg;
    logic [1:0]  mop_reg, msp_reg, sop_reg, err_reg;
    logic [12:0] maddr_reg;
    logic [23:0] mwd_reg;
    logic [2:0]  sbytes_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept = in_valid && !in_stall;

    logic [2:0]  fmt;
    logic [2:0]  bytes_raw, bytes_eff;
    assign fmt = desc_reg[0][12:10];
    always_comb
    begin
        unique case (fmt)
            3'd1: bytes_raw = 3'd2;
            3'd2, 3'd6: bytes_raw = 3'd4;
            default: bytes_raw = 3'd0;
        endcase
        bytes_eff = (bytes_raw == 3'd0) ? 3'd4 : bytes_raw;
    end

    // fetch decode of the last word uses the arriving word as the size word
    logic [23:0] w_ctrl, w_count, w_moff, w_off, w_base, w_size;
    logic [2:0]  w_fmt, w_bytes;
    logic [26:0] need;
    assign w_ctrl = desc_reg[0];
    assign w_count = desc_reg[1];
    assign w_moff = desc_reg[2];
    assign w_off = desc_reg[3];
    assign w_base = desc_reg[4];
    assign w_size = mem_rdata;
    assign w_fmt = w_ctrl[12:10];
    always_comb
    begin
        unique case (w_fmt)
            3'd1: w_bytes = 3'd2;
            3'd2, 3'd6: w_bytes = 3'd4;
            default: w_bytes = 3'd0;
        endcase
    end
    // item size is 2 or 4 here, so scale the count by a shift
    assign need = {3'd0, w_off} + ((w_bytes == 3'd2) ? {2'd0, w_count, 1'b0}
                                                     : {1'b0, w_count, 2'b0});

    // mapping of a 25-bit DSP address
    function automatic logic [15:0] map_addr(input logic [24:0] a);
        logic [15:0] res;
        begin
            res = 16'd0;
            if (a < 25'h1800) res = {1'b1, SP_X, a[12:0]};
            else if (a < 25'h2000) res = {1'b1, SP_Y, 13'(a - 25'h1800)};
            else if (a >= 25'h2800 && a < 25'h3800) res = {1'b1, SP_P, 13'(a - 25'h2800)};
            return res;
        end
    endfunction

    logic [24:0] maddr_in;
    logic [15:0] mapped;
    logic [15:0] chain_map;
    logic [23:0] item_inc;
    assign item_inc = item_reg + 24'd1;
    assign mapped = map_addr(maddr_in);
    assign chain_map = map_addr({11'd0, next_ptr_next[13:0]});

    always_comb
    begin
        config_next_c = config_reg;
        start_next_c = start_reg;
        next_ptr_next = next_ptr_reg;
        scr_ptr_next = scr_ptr_reg;
        flags_next = flags_reg;
        eol_next = eol_reg;
        phase_next = phase_reg;
        widx_next = widx_reg;
        node_next = node_reg;
        item_next = item_reg;
        desc_we = 1'b0;
        desc_wa = 3'd0;
        maddr_in = 25'd0;
        r_rdata = 32'd0; r_mop = OP_NONE; r_msp = 2'd0; r_maddr = 13'd0; r_mwd = 24'd0;
        r_sop = OP_NONE; r_saddr = 32'd0; r_sbytes = 3'd0; r_swd = 32'd0; r_err = ERR_NONE;
        if (action == ACT_WRITE) begin
            unique case (reg_select)
                REG_CONFIG: config_next_c = write_value;
                REG_START: start_next_c = write_value;
                REG_NEXT: next_ptr_next = write_value;
                REG_CONTROL:
                begin
                    unique case (write_value[2:0])
                        CTL_START: flags_next = (flags_reg | 3'b010) & ~3'b100;
                        CTL_STOP: flags_next = (flags_reg | 3'b100) & ~3'b010;
                        CTL_FREEZE: flags_next = flags_reg | 3'b001;
                        CTL_UNFREEZE: flags_next = flags_reg & ~3'b001;
                        default: flags_next = flags_reg;
                    endcase
                    if (phase_reg == PH_IDLE) widx_next = WIDX_OWED;
                end
            endcase
        end else if (action == ACT_READ) begin
            unique case (reg_select)
                REG_CONFIG: r_rdata = config_reg;
                REG_CONTROL: r_rdata = {26'd0, flags_reg, 3'd0};
                REG_START: r_rdata = start_reg;
                REG_NEXT: r_rdata = next_ptr_reg;
            endcase
        end else if (action == ACT_MEM_RET && phase_reg == PH_FETCH) begin
            if (widx_reg == 3'd0) begin
                next_ptr_next = {8'd0, mem_rdata};
                if (mem_rdata[14]) eol_next = 1'b1;
            end else if (widx_reg <= 3'd5) begin
                desc_we = 1'b1;
                desc_wa = widx_reg - 3'd1;
            end
            if (widx_reg < 3'd6) begin
                widx_next = widx_reg + 3'd1;
                maddr_in = {11'd0, node_reg} + {22'd0, widx_next};
                if (mapped[15]) begin
                    r_mop = OP_READ; r_msp = mapped[14:13]; r_maddr = mapped[12:0];
                end else begin
                    r_err = ERR_MAP; phase_next = PH_IDLE; widx_next = 3'd0;
                    flags_next = (flags_reg & ~3'b010) | 3'b100;
                end
            end else begin
                desc_we = 1'b1;
                desc_wa = 3'd5;
                if (w_bytes == 3'd0) begin
                    r_err = ERR_FORMAT; phase_next = PH_IDLE; widx_next = 3'd0;
                    flags_next = (flags_reg & ~3'b010) | 3'b100;
                end else if (w_ctrl[8:5] == BUF_CIRCULAR
                             && need >= {3'd0, w_size} + 27'd1) begin
                    phase_next = PH_IDLE; widx_next = WIDX_OWED;
                end else begin
                    scr_ptr_next = (w_ctrl[8:5] == BUF_CIRCULAR)
                        ? {8'd0, w_base} + {8'd0, w_off} : {8'd0, w_off};
                    item_next = 24'd0;
                    if (w_count == 24'd0) begin
                        phase_next = PH_IDLE; widx_next = WIDX_OWED;
                    end else if (w_ctrl[1]) begin
                        phase_next = PH_TOSCR;
                        maddr_in = {1'b0, w_moff};
                        if (mapped[15]) begin
                            r_mop = OP_READ; r_msp = mapped[14:13]; r_maddr = mapped[12:0];
                        end else begin
                            r_err = ERR_MAP; phase_next = PH_IDLE; widx_next = 3'd0;
                            flags_next = (flags_reg & ~3'b010) | 3'b100;
                        end
                    end else begin
                        phase_next = PH_FROMSCR;
                        r_sop = OP_READ; r_saddr = scr_ptr_next; r_sbytes = w_bytes;
                    end
                end
            end
        end else if (action == ACT_MEM_RET && phase_reg == PH_TOSCR) begin
            r_sop = OP_WRITE; r_saddr = scr_ptr_reg; r_sbytes = bytes_eff;
            r_swd = (bytes_eff == 3'd2) ? {16'd0, mem_rdata[15:0]} : {8'd0, mem_rdata};
            scr_ptr_next = scr_ptr_reg + {29'd0, bytes_eff};
            item_next = item_inc;
            if (item_inc >= desc_reg[1]) begin
                phase_next = PH_IDLE; widx_next = WIDX_OWED;
            end else begin
                maddr_in = {1'b0, desc_reg[2]} + {1'b0, item_inc};
                if (mapped[15]) begin
                    r_mop = OP_READ; r_msp = mapped[14:13]; r_maddr = mapped[12:0];
                end else begin
                    r_err = ERR_MAP; phase_next = PH_IDLE; widx_next = 3'd0;
                    flags_next = (flags_reg & ~3'b010) | 3'b100;
                end
            end
        end else if (action == ACT_SCR_RET && phase_reg == PH_FROMSCR) begin
            maddr_in = {1'b0, desc_reg[2]} + {1'b0, item_reg};
            if (mapped[15]) begin
                r_mop = OP_WRITE; r_msp = mapped[14:13]; r_maddr = mapped[12:0];
                r_mwd = (bytes_eff == 3'd2) ? {8'd0, scratch_rdata[15:0]}
                                            : scratch_rdata[23:0];
                scr_ptr_next = scr_ptr_reg + {29'd0, bytes_eff};
                item_next = item_inc;
                if (item_inc >= desc_reg[1]) begin
                    phase_next = PH_IDLE; widx_next = WIDX_OWED;
                end else begin
                    r_sop = OP_READ; r_saddr = scr_ptr_next; r_sbytes = bytes_eff;
                end
            end else begin
                r_err = ERR_MAP; phase_next = PH_IDLE; widx_next = 3'd0;
                flags_next = (flags_reg & ~3'b010) | 3'b100;
            end
        end
        // take an owed chain step when the DSP port is free
        if (phase_next == PH_IDLE && widx_next == WIDX_OWED && r_mop == OP_NONE) begin
            widx_next = 3'd0;
            if (flags_next[1] && !flags_next[0] && !next_ptr_next[14]) begin
                node_next = next_ptr_next[13:0];
                phase_next = PH_FETCH;
                if (chain_map[15]) begin
                    r_mop = OP_READ; r_msp = chain_map[14:13]; r_maddr = chain_map[12:0];
                end else begin
                    r_err = ERR_MAP; phase_next = PH_IDLE;
                    flags_next = (flags_next & ~3'b010) | 3'b100;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            config_reg <= 32'd0; start_reg <= 32'd0; next_ptr_reg <= 32'd0;
            scr_ptr_reg <= 32'd0; flags_reg <= 3'd0; eol_reg <= 1'b0;
            phase_reg <= PH_IDLE; widx_reg <= 3'd0; node_reg <= 14'd0;
            item_reg <= 24'd0; out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                config_reg <= config_next_c; start_reg <= start_next_c;
                next_ptr_reg <= next_ptr_next; scr_ptr_reg <= scr_ptr_next;
                flags_reg <= flags_next; eol_reg <= eol_next; phase_reg <= phase_next;
                widx_reg <= widx_next; node_reg <= node_next; item_reg <= item_next;
            end
            if (accept) out_valid_reg <= 1'b1;
            else if (!out_stall) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && desc_we) desc_reg[desc_wa] <= mem_rdata;
        if (accept) begin
            rdata_reg <= r_rdata; mop_reg <= r_mop; msp_reg <= r_msp; maddr_reg <= r_maddr;
            mwd_reg <= r_mwd; sop_reg <= r_sop; saddr_reg <= r_saddr;
            sbytes_reg <= r_sbytes; swd_reg <= r_swd; err_reg <= r_err;
        end
    end

    assign out_valid = out_valid_reg;
    assign reg_rdata = rdata_reg;
    assign mem_op = mop_reg;
    assign mem_region = msp_reg;
    assign mem_addr = maddr_reg;
    assign mem_wdata = mwd_reg;
    assign scratch_op = sop_reg;
    assign scratch_loc = saddr_reg;
    assign scratch_bytes = sbytes_reg;
    assign scratch_wdata = swd_reg;
    assign error = err_reg;
endmodule

@@ rtl/core/dcd_checker.sv @@
// Port checker for the descriptor chain DMA engine and its bind
`include "descriptor_chain_dma_engine_unit_defines.svh"
module dcd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  mem_op,
    input logic [1:0]  scratch_op,
    input logic [2:0]  scratch_bytes,
    input logic [1:0]  error
);
    import dcd_pkg::*;
    `DCD_ASSERT_IMP(a_stall_only_full, clk, rst_n, in_stall, out_valid && out_stall, "stall without held word")
    `DCD_ASSERT_NEXT(a_accept_gives_word, clk, rst_n, in_valid && !in_stall, out_valid, "accepted word lost")
    `DCD_ASSERT_IMP(a_err_no_mem, clk, rst_n, out_valid && error != ERR_NONE, mem_op == OP_NONE, "request on error")
    `DCD_ASSERT_IMP(a_bytes_ok, clk, rst_n, out_valid && scratch_op != OP_NONE, scratch_bytes == 3'd2 || scratch_bytes == 3'd4, "bad item size")
endmodule

bind descriptor_chain_dma_engine_unit dcd_checker u_dcd_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .mem_op(mem_op),
    .scratch_op(scratch_op), .scratch_bytes(scratch_bytes), .error(error)
);

@@ sim/descriptor_chain_dma_engine_unit_tb.sv @@
// Testbench for the descriptor chain DMA engine: random and directed words against a predictor
`timescale 1ns / 100ps

module descriptor_chain_dma_engine_unit_tb;
    import dcd_pkg::*;

    typedef struct {
        logic [1:0]  action;
        logic [1:0]  reg_select;
        logic [31:0] write_value;
        logic [23:0] mem_rdata;
        logic [31:0] scratch_rdata;
    } dma_word_t;

    typedef struct {
        logic [31:0] reg_rdata;
        logic [1:0]  mem_op;
        logic [1:0]  mem_region;
        logic [12:0] mem_addr;
        logic [23:0] mem_wdata;
        logic [1:0]  scratch_op;
        logic [31:0] scratch_loc;
        logic [2:0]  scratch_bytes;
        logic [31:0] scratch_wdata;
        logic [1:0]  error;
    } dma_result_t;

    class dma_scoreboard;
        bit [31:0]   cfg_reg;
        bit [31:0]   start_reg;
        bit [31:0]   next_reg;
        bit [2:0]    flags;
        bit          eol_mark;
        phase_t      seq_phase;
        bit [2:0]    widx;
        bit [13:0]   node;
        bit [23:0]   desc [6];
        bit [23:0]   item_idx;
        bit [31:0]   scr_ptr;
        dma_result_t expected_results [$];
        int          errors;

        function new();
            cfg_reg = 0;
            start_reg = 0;
            next_reg = 0;
            flags = 0;
            eol_mark = 0;
            seq_phase = PH_IDLE;
            widx = 0;
            node = 0;
            foreach (desc[k]) desc[k] = 0;
            item_idx = 0;
            scr_ptr = 0;
            errors = 0;
        endfunction

        task report(string what, bit [31:0] got, bit [31:0] exp);
            $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $time);
            errors++;
        endtask

        function void halt(inout dma_result_t r, input logic [1:0] code);
            r.error = code;
            seq_phase = PH_IDLE;
            widx = 0;
            flags = (flags & 3'b101) | 3'b100;
        endfunction

        function bit dsp_request(inout dma_result_t r, input logic [1:0] op,
                                 input bit [31:0] a, input bit [23:0] wd);
            bit [31:0] off;
            logic [1:0] sp;
            if (a < 32'h1800) begin
                sp = SP_X;
                off = a;
            end
            else if (a < 32'h2000) begin
                sp = SP_Y;
                off = a - 32'h1800;
            end
            else if (a >= 32'h2800 && a < 32'h3800) begin
                sp = SP_P;
                off = a - 32'h2800;
            end
            else begin
                halt(r, ERR_MAP);
                return 0;
            end
            r.mem_op = op;
            r.mem_region = sp;
            r.mem_addr = off[12:0];
            r.mem_wdata = (op == OP_WRITE) ? wd : 24'd0;
            return 1;
        endfunction

        function bit [2:0] fmt_bytes();
            case (desc[0][12:10])
                3'd1: return 3'd2;
                3'd2, 3'd6: return 3'd4;
                default: return 3'd0;
            endcase
        endfunction

        function void scratch_request(inout dma_result_t r, input logic [1:0] op,
                                      input bit [2:0] nbytes, input bit [31:0] data);
            r.scratch_op = op;
            r.scratch_loc = scr_ptr;
            r.scratch_bytes = nbytes;
            if (op == OP_WRITE)
                r.scratch_wdata = (nbytes == 3'd2) ? (data & 32'hffff) : data;
            else
                r.scratch_wdata = 0;
        endfunction

        function void owe_step();
            seq_phase = PH_IDLE;
            widx = WIDX_OWED;
        endfunction

        function void start_transfer(inout dma_result_t r);
            bit [2:0] nbytes;
            longint unsigned need;
            bit ok;
            nbytes = fmt_bytes();
            if (nbytes == 0) begin
                halt(r, ERR_FORMAT);
                return;
            end
            if (desc[0][8:5] == BUF_CIRCULAR) begin
                need = longint'(desc[3]) + longint'(desc[1]) * longint'(nbytes);
                if (need >= longint'(desc[5]) + 1) begin
                    owe_step();
                    return;
                end
                scr_ptr = {8'd0, desc[4]} + {8'd0, desc[3]};
            end
            else
                scr_ptr = {8'd0, desc[3]};
            item_idx = 0;
            if (desc[1] == 0) begin
                owe_step();
                return;
            end
            if (desc[0][1]) begin
                seq_phase = PH_TOSCR;
                ok = dsp_request(r, OP_READ, {8'd0, desc[2]}, 0);
            end
            else begin
                seq_phase = PH_FROMSCR;
                scratch_request(r, OP_READ, nbytes, 0);
            end
        endfunction

        // Work out the result of one accepted word and queue it.
        function void note_input(dma_word_t w);
            dma_result_t r;
            bit [2:0] nbytes;
            bit [2:0] wi;
            bit [31:0] val;
            bit ok;
            r = '{default: 0};
            if (w.action == ACT_WRITE) begin
                case (w.reg_select)
                    REG_CONFIG: cfg_reg = w.write_value;
                    REG_START: start_reg = w.write_value;
                    REG_NEXT: next_reg = w.write_value;
                    default:
                    begin
                        case (w.write_value[2:0])
                            CTL_START: flags = (flags | 3'b010) & 3'b011;
                            CTL_STOP: flags = (flags | 3'b100) & 3'b101;
                            CTL_FREEZE: flags = flags | 3'b001;
                            CTL_UNFREEZE: flags = flags & 3'b110;
                            default: ;
                        endcase
                        if (seq_phase == PH_IDLE) widx = WIDX_OWED;
                    end
                endcase
            end
            else if (w.action == ACT_READ) begin
                case (w.reg_select)
                    REG_CONFIG: r.reg_rdata = cfg_reg;
                    REG_CONTROL: r.reg_rdata = {26'd0, flags, 3'd0};
                    REG_START: r.reg_rdata = start_reg;
                    default: r.reg_rdata = next_reg;
                endcase
            end
            else if (w.action == ACT_MEM_RET && seq_phase == PH_FETCH) begin
                wi = widx;
                if (wi == 0) begin
                    next_reg = {8'd0, w.mem_rdata};
                    if (w.mem_rdata[14]) eol_mark = 1;
                end
                else if (wi <= 6)
                    desc[wi - 1] = w.mem_rdata;
                if (wi < 6) begin
                    widx = wi + 1;
                    ok = dsp_request(r, OP_READ, {18'd0, node} + widx, 0);
                end
                else
                    start_transfer(r);
            end
            else if (w.action == ACT_MEM_RET && seq_phase == PH_TOSCR) begin
                nbytes = fmt_bytes();
                if (nbytes == 0) nbytes = 3'd4;
                scratch_request(r, OP_WRITE, nbytes, {8'd0, w.mem_rdata});
                scr_ptr += nbytes;
                item_idx = item_idx + 1;
                if (item_idx >= desc[1])
                    owe_step();
                else
                    ok = dsp_request(r, OP_READ, {8'd0, desc[2]} + {8'd0, item_idx}, 0);
            end
            else if (w.action == ACT_SCR_RET && seq_phase == PH_FROMSCR) begin
                nbytes = fmt_bytes();
                if (nbytes == 0) nbytes = 3'd4;
                val = (nbytes == 3'd2) ? (w.scratch_rdata & 32'hffff)
                                       : (w.scratch_rdata & 32'hffffff);
                if (dsp_request(r, OP_WRITE, {8'd0, desc[2]} + {8'd0, item_idx}, val[23:0]))
                begin
                    scr_ptr += nbytes;
                    item_idx = item_idx + 1;
                    if (item_idx >= desc[1])
                        owe_step();
                    else
                        scratch_request(r, OP_READ, nbytes, 0);
                end
            end
            // take an owed chain step once the DSP port is free
            if (seq_phase == PH_IDLE && widx == WIDX_OWED && r.mem_op == OP_NONE) begin
                widx = 0;
                if (flags[1] && !flags[0] && !next_reg[14]) begin
                    node = next_reg[13:0];
                    seq_phase = PH_FETCH;
                    ok = dsp_request(r, OP_READ, {18'd0, node}, 0);
                end
            end
            expected_results.push_back(r);
        endfunction

        task check_result(dma_result_t g);
            dma_result_t e;
            if (expected_results.size() == 0) begin
                report("result with nothing expected", g.reg_rdata, 0);
                return;
            end
            e = expected_results.pop_front();
            if (g.reg_rdata !== e.reg_rdata) report("reg_rdata", g.reg_rdata, e.reg_rdata);
            if (g.mem_op !== e.mem_op) report("mem_op", g.mem_op, e.mem_op);
            if (g.mem_region !== e.mem_region)
                report("mem_region", g.mem_region, e.mem_region);
            if (g.mem_addr !== e.mem_addr) report("mem_addr", g.mem_addr, e.mem_addr);
            if (g.mem_wdata !== e.mem_wdata) report("mem_wdata", g.mem_wdata, e.mem_wdata);
            if (g.scratch_op !== e.scratch_op)
                report("scratch_op", g.scratch_op, e.scratch_op);
            if (g.scratch_loc !== e.scratch_loc)
                report("scratch_loc", g.scratch_loc, e.scratch_loc);
            if (g.scratch_bytes !== e.scratch_bytes)
                report("scratch_bytes", g.scratch_bytes, e.scratch_bytes);
            if (g.scratch_wdata !== e.scratch_wdata)
                report("scratch_wdata", g.scratch_wdata, e.scratch_wdata);
            if (g.error !== e.error) report("error", g.error, e.error);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [1:0]  reg_select;
    logic [31:0] write_value;
    logic [23:0] mem_rdata;
    logic [31:0] scratch_rdata;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] reg_rdata;
    logic [1:0]  mem_op;
    logic [1:0]  mem_region;
    logic [12:0] mem_addr;
    logic [23:0] mem_wdata;
    logic [1:0]  scratch_op;
    logic [31:0] scratch_loc;
    logic [2:0]  scratch_bytes;
    logic [31:0] scratch_wdata;
    logic [1:0]  error;

    dma_scoreboard sb;
    int tx_idle_pct;
    int rx_idle_pct;
    int hold_req;
    int quiet_cycles;

    descriptor_chain_dma_engine_unit dut (.*);

    initial clk = 0;
    always #6 clk = ~clk;

    function automatic dma_word_t mk(logic [1:0] a, logic [1:0] s, logic [31:0] v,
                                     logic [23:0] md, logic [31:0] sd);
        dma_word_t w;
        w.action = a;
        w.reg_select = s;
        w.write_value = v;
        w.mem_rdata = md;
        w.scratch_rdata = sd;
        return w;
    endfunction

    function automatic logic [23:0] dsp_target();
        case ($urandom_range(0, 7))
            0, 1, 2: return 24'($urandom_range(0, 32'h17ff));
            3: return 24'($urandom_range(32'h1800, 32'h1fff));
            4, 5: return 24'($urandom_range(32'h2800, 32'h37ff));
            6: return 24'($urandom);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return 24'h17fd;
                    1: return 24'h1ffc;
                    2: return 24'h37fb;
                    3: return 24'h2000;
                    default: return 24'h3800;
                endcase
            end
        endcase
    endfunction

    function automatic logic [23:0] descriptor_field(bit [2:0] wi);
        logic [23:0] v;
        v = 24'($urandom);
        case (wi)
            3'd0:
            begin
                v = dsp_target();
                v[14] = ($urandom_range(0, 4) == 0);
            end
            3'd1:
            begin
                v[1] = 1'($urandom);
                if ($urandom_range(0, 2) == 0) v[8:5] = BUF_CIRCULAR;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: v[12:10] = 3'd1;
                    4, 5, 6: v[12:10] = 3'd2;
                    7, 8: v[12:10] = 3'd6;
                    default: ;
                endcase
            end
            3'd2: v = ($urandom_range(0, 29) == 0) ? 24'($urandom_range(7, 40))
                                                   : 24'($urandom_range(0, 6));
            3'd3: v = dsp_target();
            3'd4: if ($urandom_range(0, 1)) v = 24'($urandom_range(0, 64));
            3'd6: if ($urandom_range(0, 1)) v = 24'($urandom_range(0, 96));
            default: ;
        endcase
        return v;
    endfunction

    // Pick the next word: mostly well-formed traffic for the current phase.
    function automatic dma_word_t next_word();
        dma_word_t w;
        logic [31:0] v;
        w = mk(2'($urandom), 2'($urandom), $urandom, 24'($urandom), $urandom);
        if ($urandom_range(0, 99) < 8) return w;
        case (sb.seq_phase)
            PH_FETCH: w.action = ACT_MEM_RET;
            PH_TOSCR: w.action = ACT_MEM_RET;
            PH_FROMSCR: w.action = ACT_SCR_RET;
            default:
            begin
                case ($urandom_range(0, 9))
                    0: w.action = ACT_READ;
                    1:
                    begin
                        w.action = ACT_WRITE;
                        w.reg_select = $urandom_range(0, 1) ? REG_CONFIG : REG_START;
                    end
                    2:
                    begin
                        w.action = ACT_WRITE;
                        w.reg_select = REG_CONTROL;
                    end
                    3, 4, 5:
                    begin
                        v = $urandom;
                        v[14] = 0;
                        v[13:0] = 14'(dsp_target());
                        w = mk(ACT_WRITE, REG_NEXT, v, 24'($urandom), $urandom);
                    end
                    default:
                    begin
                        v = $urandom;
                        v[2:0] = sb.flags[0] ? CTL_UNFREEZE : CTL_START;
                        w = mk(ACT_WRITE, REG_CONTROL, v, 24'($urandom), $urandom);
                    end
                endcase
            end
        endcase
        if (sb.seq_phase == PH_FETCH) w.mem_rdata = descriptor_field(sb.widx);
        return w;
    endfunction

    task automatic send_word(dma_word_t w);
        in_valid <= 1'b1;
        action <= w.action;
        reg_select <= w.reg_select;
        write_value <= w.write_value;
        mem_rdata <= w.mem_rdata;
        scratch_rdata <= w.scratch_rdata;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        sb.note_input(w);
    endtask

    task automatic maybe_gap();
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // result side: stall at random, hold off on request, check every word taken
    initial begin : result_side
        dma_result_t got;
        bit took;
        took = 0;
        out_stall = 0;
        forever begin
            @(posedge clk);
            if (took) sb.check_result(got);
            if (hold_req > 0) begin
                out_stall <= 1'b1;
                hold_req--;
            end
            else
                out_stall <= (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct);
            @(negedge clk);
            took = rst_n && out_valid && !out_stall;
            got = '{reg_rdata, mem_op, mem_region, mem_addr, mem_wdata, scratch_op,
                    scratch_loc, scratch_bytes, scratch_wdata, error};
        end
    end

    always @(negedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= 3000) begin
                $display("[descriptor_chain_dma_engine_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin : word_source
        dma_word_t plan [$];
        sb = new();
        quiet_cycles = 0;
        hold_req = 0;
        tx_idle_pct = 13;
        rx_idle_pct = 51;
        rst_n = 0;
        in_valid = 0;
        action = 0;
        reg_select = 0;
        write_value = 0;
        mem_rdata = 0;
        scratch_rdata = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // registers after reset, extremes, end-of-list start
        plan.push_back(mk(ACT_READ, REG_CONFIG, 0, 0, 0));
        plan.push_back(mk(ACT_READ, REG_CONTROL, 0, 0, 0));
        plan.push_back(mk(ACT_READ, REG_START, 0, 0, 0));
        plan.push_back(mk(ACT_READ, REG_NEXT, 0, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_CONFIG, 32'hffffffff, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_START, 32'hffffffff, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_NEXT, 32'h00004000, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_CONTROL, {29'd0, CTL_START}, 0, 0));
        // descriptor straddling X and Y, then an item run into the unmapped hole
        plan.push_back(mk(ACT_WRITE, REG_NEXT, 32'h000017fa, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_CONTROL, {29'd0, CTL_START}, 0, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'h004000, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'h000402, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'h000002, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'h0037ff, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'hffffff, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'h000000, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'hffffff, 0));
        plan.push_back(mk(ACT_MEM_RET, 0, 0, 24'hffffff, 0));
        // stray response, undefined control code, freeze and unfreeze, stop
        plan.push_back(mk(ACT_SCR_RET, 0, 0, 0, 32'hffffffff));
        plan.push_back(mk(ACT_WRITE, REG_CONTROL, 32'hffffffff, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_CONTROL, {29'd0, CTL_FREEZE}, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_CONTROL, {29'd0, CTL_UNFREEZE}, 0, 0));
        plan.push_back(mk(ACT_WRITE, REG_CONTROL, {29'd0, CTL_STOP}, 0, 0));
        plan.push_back(mk(ACT_READ, REG_CONTROL, 0, 0, 0));
        foreach (plan[k]) begin
            maybe_gap();
            send_word(plan[k]);
        end

        for (int i = 0; i < 1850; i++) begin
            if (i == 620) begin
                tx_idle_pct = 51;
                rx_idle_pct = 13;
            end
            if (i == 1240) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (i == 700) begin
                // drain before going on
                in_valid <= 1'b0;
                while (sb.expected_results.size() > 0) @(posedge clk);
            end
            if (i == 1400) hold_req = 300;
            maybe_gap();
            send_word(next_word());
        end
        in_valid <= 1'b0;
        while (sb.expected_results.size() > 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("[descriptor_chain_dma_engine_unit] OK");
        else
            $display("[descriptor_chain_dma_engine_unit] ERROR");
        $finish;
    end
endmodule
